### src/psfutd_pkg.sv
// ----------------------------------------------------------------------------
// psfutd_pkg
// Shared types and constants for the unicode table decoder.
// ----------------------------------------------------------------------------
package psfutd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned GLYPH_W = 16;
  localparam int unsigned PEND_W  = 2;

  localparam logic [BYTE_W-1:0] BYTE_NEXT_GLYPH = 8'hFF;
  localparam logic [BYTE_W-1:0] MASK_LEAD2      = 8'h1F;
  localparam logic [BYTE_W-1:0] MASK_LEAD3      = 8'h0F;
  localparam logic [BYTE_W-1:0] MASK_LEAD4      = 8'h07;
  localparam logic [BYTE_W-1:0] MASK_CONT       = 8'h3F;

  localparam int unsigned CONT_BITS = 6;

  localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
  localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [GLYPH_W-1:0] glyph_t;

  typedef struct packed {
    code_t  code_point;
    glyph_t glyph_index;
  } result_t;

endpackage

### src/psf_unicode_table_decoder_core.sv
// ----------------------------------------------------------------------------
// psf_unicode_table_decoder_core
// Results are registered in the result register, or the skid when it is stalled.
// One table byte per cycle unless stalled, limited by the single decode stage.
// A two-entry output buffer (result register plus skid) keeps input flowing
// while the output is stalled; input stalls only when both entries are full.
// Reset (rst, synchronous): counter, partial code, pending count, table enable
// and both output entries clear; the block is ready the cycle after.
// ----------------------------------------------------------------------------
module psf_unicode_table_decoder_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [psfutd_pkg::BYTE_W-1:0] table_byte,
  input  logic                          end_of_table,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [psfutd_pkg::CODE_W-1:0] code_point,
  output logic [psfutd_pkg::GLYPH_W-1:0] glyph_index
);
  import psfutd_pkg::*;

  logic                table_enabled;
  glyph_t              glyph_counter, glyph_counter_next;
  code_t               partial_code, partial_code_next;
  logic [PEND_W-1:0]   bytes_pending, bytes_pending_next;
  logic                done;
  code_t               code;
  result_t             out_reg, skid_reg, result;
  logic                skid_valid;
  logic                accept, push, pop;

  assign accept = in_valid && !in_stall;
  assign in_stall = skid_valid;
  assign pop = out_valid && !out_stall;

  always_comb begin
    glyph_counter_next = glyph_counter;
    partial_code_next  = partial_code;
    bytes_pending_next = bytes_pending;
    done = 1'b0;
    code = '0;
    if (bytes_pending != PEND_NONE) begin
      partial_code_next  = {partial_code[CODE_W-CONT_BITS-1:0],
                            table_byte[CONT_BITS-1:0]};
      bytes_pending_next = bytes_pending - PEND_ONE;
      if (bytes_pending == PEND_ONE) begin
        done = 1'b1;
        code = partial_code_next;
      end
    end else if (table_byte == BYTE_NEXT_GLYPH) begin
      glyph_counter_next = glyph_counter + GLYPH_W'(1);
    end else if (!table_byte[7]) begin
      done = 1'b1;
      code = CODE_W'(table_byte);
    end else if (!table_byte[5]) begin
      partial_code_next  = CODE_W'(table_byte & MASK_LEAD2);
      bytes_pending_next = PEND_ONE;
    end else if (!table_byte[4]) begin
      partial_code_next  = CODE_W'(table_byte & MASK_LEAD3);
      bytes_pending_next = PEND_TWO;
    end else if (!table_byte[3]) begin
      partial_code_next  = CODE_W'(table_byte & MASK_LEAD4);
      bytes_pending_next = PEND_THREE;
    end else begin
      done = 1'b1;
      code = '0;
    end
    if (end_of_table) begin
      glyph_counter_next = '0;
      partial_code_next  = '0;
      bytes_pending_next = PEND_NONE;
    end
  end

  assign result.code_point  = code;
  assign result.glyph_index = glyph_counter;
  assign push = accept && done && table_enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_enabled <= 1'b0;
      glyph_counter <= '0;
      partial_code  <= '0;
      bytes_pending <= PEND_NONE;
    end else begin
      if (cfg_write) begin
        table_enabled <= cfg_data;
      end
      if (accept) begin
        glyph_counter <= glyph_counter_next;
        partial_code  <= partial_code_next;
        bytes_pending <= bytes_pending_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_reg   <= result;
        out_valid <= 1'b1;
      end else begin
        skid_reg   <= result;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign code_point  = out_reg.code_point;
  assign glyph_index = out_reg.glyph_index;

endmodule

### src/psfutd_checker.sv
// ----------------------------------------------------------------------------
// psfutd_checker
// Port-level checks on the decoder's request channels and output buffering.
// ----------------------------------------------------------------------------
module psfutd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [psfutd_pkg::CODE_W-1:0] code_point,
  input logic [psfutd_pkg::GLYPH_W-1:0] glyph_index
);
  import psfutd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_point) && $stable(glyph_index))
    else $error("stalled output request changed");

  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |=> !in_stall)
    else $error("input stalled after empty output");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output buffer not cleared by reset");

endmodule

bind psf_unicode_table_decoder_core psfutd_checker u_psfutd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .code_point  (code_point),
  .glyph_index (glyph_index)
);
